@@ hdl/wdrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wdrd_pkg;
   // result status codes
   typedef enum logic [2:0] {
      ST_PROTO_MISMATCH = 3'd0,
      ST_UNATTRIBUTED   = 3'd1,
      ST_FILTERED       = 3'd2,
      ST_COUNTED        = 3'd3,
      ST_THRESHOLD      = 3'd4
   } status_type;

   // configuration register indexes
   localparam logic [1:0] CSR_MATCH_PROTOCOL = 2'd0;
   localparam logic [1:0] CSR_IFACE_FILTER   = 2'd1;
   localparam logic [1:0] CSR_WINDOW_NS      = 2'd2;
   localparam logic [1:0] CSR_DROP_THRESHOLD = 2'd3;

   localparam logic [31:0] COUNT_MAX  = 32'hffff_ffff;
   localparam logic [7:0]  DETAIL_MAX = 8'hff;

   // key, time and window broadcast to every cell
   typedef struct packed {
      logic [2:0]  cpu;
      logic [31:0] iface;
      logic [63:0] now;
      logic [63:0] window;
   } probe_type;

   // per-cell report
   typedef struct packed {
      logic        hit;
      logic        restart;
      logic [63:0] elapsed;
      logic [31:0] count;
   } report_type;
endpackage
`default_nettype wire

@@ hdl/windowed_drop_rate_detector.sv @@
`timescale 1ns / 1ps
// Result strobe rsp_valid is registered and rises in the cycle after the accepting edge.
// Throughput: one transaction per cycle; busy is never raised.
// The tag match runs across the row of cells in the same cycle.
// Reset (synchronous, active high) clears valid bits, totals, configuration
// registers and rsp_valid, and sets LRU ages to index order. The receiver cannot stall.
`default_nettype none
module windowed_drop_rate_detector #(
   parameter int ENTRIES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [63:0] req_time_ns,
   input  wire  [2:0]  req_cpu_id,
   input  wire  [31:0] req_iface_id,
   input  wire  [15:0] req_drop_protocol,
   input  wire  [31:0] req_drop_reason,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_window_count,
   output logic [63:0] rsp_elapsed_ns,
   output logic [7:0]  rsp_reason_detail,
   output logic [31:0] rsp_event_iface,
   output logic [2:0]  rsp_event_cpu,
   output logic [63:0] rsp_event_time,
   output logic [63:0] rsp_drops_total,
   output logic [63:0] rsp_unattributed_total,
   output logic [63:0] rsp_events_total,
   input  wire         csr_write,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_data
);
   localparam int AGE_W = $clog2(ENTRIES);

   logic [15:0] proto_ff;
   logic [31:0] filter_ff;
   logic [63:0] window_ff;
   logic [31:0] thresh_ff;
   logic [63:0] drops_ff, unattr_ff, events_ff;

   wdrd_pkg::probe_type  probe;
   wdrd_pkg::report_type rpt [ENTRIES];
   logic [AGE_W-1:0]     age [ENTRIES];
   logic [ENTRIES-1:0]   hits, sel;
   logic [AGE_W-1:0]     sel_age, hit_idx, lru_idx, idx;
   logic                 any_hit, counting, upd;
   wdrd_pkg::report_type hr;
   logic [31:0]          count;
   logic [63:0]          elapsed;
   logic [7:0]           detail;
   wdrd_pkg::status_type status;

   assign busy = 1'b0;
   assign probe = '{cpu: req_cpu_id, iface: req_iface_id, now: req_time_ns,
                    window: window_ff};

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff <= '0; filter_ff <= '0; window_ff <= '0; thresh_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            wdrd_pkg::CSR_MATCH_PROTOCOL: proto_ff <= csr_data[15:0];
            wdrd_pkg::CSR_IFACE_FILTER:   filter_ff <= csr_data[31:0];
            wdrd_pkg::CSR_WINDOW_NS:      window_ff <= csr_data;
            wdrd_pkg::CSR_DROP_THRESHOLD: thresh_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // row of cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      wdrd_cell #(.AGE_W(AGE_W), .AGE_INIT(AGE_W'(g))) u_cell (
         .clock(clock), .reset(reset), .probe(probe), .upd(upd),
         .sel(sel[g]), .fresh(!any_hit), .sel_age(sel_age),
         .rpt(rpt[g]), .age(age[g]));
      assign hits[g] = rpt[g].hit;
   end

   // pick hit slot or oldest slot
   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hits[i]) hit_idx = AGE_W'(i);
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (age[i] == {AGE_W{1'b1}} || (ENTRIES != (1 << AGE_W) &&
             age[i] == AGE_W'(ENTRIES - 1))) lru_idx = AGE_W'(i);
      end
      any_hit = |hits;
      idx = any_hit ? hit_idx : lru_idx;
      sel_age = age[idx];
      sel = '0;
      sel[idx] = 1'b1;
      hr = rpt[idx];
   end

   // classify transaction
   always_comb begin
      counting = 1'b0;
      count = '0;
      elapsed = '0;
      detail = '0;
      if (req_drop_protocol != proto_ff) status = wdrd_pkg::ST_PROTO_MISMATCH;
      else if (req_iface_id == '0) status = wdrd_pkg::ST_UNATTRIBUTED;
      else if (filter_ff != '0 && filter_ff != req_iface_id)
         status = wdrd_pkg::ST_FILTERED;
      else begin
         counting = 1'b1;
         count = 32'd1;
         if (any_hit && !hr.restart) begin
            count = hr.count;
            elapsed = hr.elapsed;
         end
         detail = req_drop_reason[31] ? 8'd0 :
                  (req_drop_reason[30:8] != '0) ? wdrd_pkg::DETAIL_MAX :
                  req_drop_reason[7:0];
         status = (count == thresh_ff) ? wdrd_pkg::ST_THRESHOLD : wdrd_pkg::ST_COUNTED;
      end
   end
   assign upd = start && counting;

   // advance totals and register result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         drops_ff <= '0; unattr_ff <= '0; events_ff <= '0;
      end else begin
         rsp_valid <= start;
         if (start) begin
            if (counting) drops_ff <= drops_ff + 64'd1;
            if (status == wdrd_pkg::ST_UNATTRIBUTED) unattr_ff <= unattr_ff + 64'd1;
            if (status == wdrd_pkg::ST_THRESHOLD) events_ff <= events_ff + 64'd1;
         end
      end
      if (start) begin
         rsp_status <= status;
         rsp_window_count <= count;
         rsp_elapsed_ns <= elapsed;
         rsp_reason_detail <= detail;
         rsp_event_iface <= req_iface_id;
         rsp_event_cpu <= req_cpu_id;
         rsp_event_time <= req_time_ns;
      end
   end
   assign rsp_drops_total = drops_ff;
   assign rsp_unattributed_total = unattr_ff;
   assign rsp_events_total = events_ff;

`ifndef ASSERT_OFF
   a_one_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hits))
      else $error("duplicate key in table");
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid) else $error("missing result strobe");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wdrd_pkg::ST_COUNTED ||
      rsp_status == wdrd_pkg::ST_THRESHOLD) |-> rsp_window_count != '0)
      else $error("zero count on counted drop");
`endif
endmodule
`default_nettype wire

@@ hdl/wdrd_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wdrd_cell #(
   parameter int AGE_W = 4,
   parameter logic [AGE_W-1:0] AGE_INIT = '0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wdrd_pkg::probe_type   probe,
   input  wire                   upd,
   input  wire                   sel,
   input  wire                   fresh,
   input  wire  [AGE_W-1:0]      sel_age,
   output wdrd_pkg::report_type  rpt,
   output logic [AGE_W-1:0]      age
);
   logic              valid_ff;
   logic [2:0]        cpu_ff;
   logic [31:0]       iface_ff;
   logic [63:0]       start_ff;
   logic [31:0]       count_ff;
   logic [AGE_W-1:0]  age_ff;
   logic [63:0]       diff;

   // match key and check window
   always_comb begin
      diff = probe.now - start_ff;
      rpt.hit = valid_ff && cpu_ff == probe.cpu && iface_ff == probe.iface;
      rpt.restart = probe.now < start_ff || diff >= probe.window;
      rpt.elapsed = diff;
      rpt.count = (count_ff == wdrd_pkg::COUNT_MAX) ? count_ff : count_ff + 32'd1;
   end
   assign age = age_ff;

   // hold entry, update on selection, age entries younger than the selected one
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff <= AGE_INIT;
      end else if (upd) begin
         if (sel) begin
            age_ff <= '0;
            valid_ff <= 1'b1;
         end else if (age_ff < sel_age) begin
            age_ff <= age_ff + AGE_W'(1);
         end
      end
      if (upd && sel) begin
         cpu_ff <= probe.cpu;
         iface_ff <= probe.iface;
         if (fresh || rpt.restart) begin
            start_ff <= probe.now;
            count_ff <= 32'd1;
         end else begin
            count_ff <= rpt.count;
         end
      end
   end
endmodule
`default_nettype wire

@@ verif/windowed_drop_rate_detector_tb.sv @@
`timescale 1ns / 1ps
module windowed_drop_rate_detector_tb;

   localparam int NKEYS = 16;

   // Input transaction
   typedef struct {
      logic [63:0] time_ns;
      logic [2:0]  cpu;
      logic [31:0] iface;
      logic [15:0] proto;
      logic [31:0] reason;
   } drop_event_type;

   // Result transaction
   typedef struct {
      wdrd_pkg::status_type status;
      logic [31:0] count;
      logic [63:0] elapsed;
      logic [7:0]  detail;
      logic [31:0] iface;
      logic [2:0]  cpu;
      logic [63:0] time_ns;
      logic [63:0] drops;
      logic [63:0] unattr;
      logic [63:0] events;
   } drop_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_time_ns = '0;
   logic [2:0]  req_cpu_id = '0;
   logic [31:0] req_iface_id = '0;
   logic [15:0] req_drop_protocol = '0;
   logic [31:0] req_drop_reason = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_window_count;
   logic [63:0] rsp_elapsed_ns;
   logic [7:0]  rsp_reason_detail;
   logic [31:0] rsp_event_iface;
   logic [2:0]  rsp_event_cpu;
   logic [63:0] rsp_event_time;
   logic [63:0] rsp_drops_total;
   logic [63:0] rsp_unattributed_total;
   logic [63:0] rsp_events_total;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   windowed_drop_rate_detector dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the detector state
   logic [15:0] sh_proto;
   logic [31:0] sh_filter;
   logic [63:0] sh_window;
   logic [31:0] sh_thresh;
   logic        key_valid [NKEYS];
   logic [2:0]  key_cpu   [NKEYS];
   logic [31:0] key_iface [NKEYS];
   logic [63:0] key_start [NKEYS];
   logic [31:0] key_count [NKEYS];
   logic [3:0]  key_age   [NKEYS];
   logic [63:0] tot_drops, tot_unattr, tot_events;

   drop_report_type pending_reports[$];
   int mismatches = 0;
   int cycles = 0;
   bit idle_gaps = 1'b1;

   task automatic shadow_reset();
      sh_proto = '0; sh_filter = '0; sh_window = '0; sh_thresh = '0;
      for (int i = 0; i < NKEYS; i++) begin
         key_valid[i] = 1'b0;
         key_age[i] = 4'(i);
      end
      tot_drops = '0; tot_unattr = '0; tot_events = '0;
   endtask

   function automatic drop_report_type classify_drop(drop_event_type ev);
      drop_report_type r;
      int slot;
      logic [3:0] old;
      logic [31:0] rsn;
      r.count = '0; r.elapsed = '0; r.detail = '0;
      r.iface = ev.iface; r.cpu = ev.cpu; r.time_ns = ev.time_ns;
      rsn = ev.reason[31] ? 32'd0 : ev.reason;
      if (ev.proto != sh_proto) begin
         r.status = wdrd_pkg::ST_PROTO_MISMATCH;
      end else if (ev.iface == 0) begin
         tot_unattr++;
         r.status = wdrd_pkg::ST_UNATTRIBUTED;
      end else if (sh_filter != 0 && sh_filter != ev.iface) begin
         r.status = wdrd_pkg::ST_FILTERED;
      end else begin
         tot_drops++;
         slot = -1;
         for (int i = 0; i < NKEYS; i++)
            if (slot < 0 && key_valid[i] && key_cpu[i] == ev.cpu && key_iface[i] == ev.iface)
               slot = i;
         r.count = 32'd1;
         if (slot < 0) begin
            slot = 0;
            for (int i = 0; i < NKEYS; i++)
               if (key_age[i] > key_age[slot]) slot = i;
            key_valid[slot] = 1'b1;
            key_cpu[slot] = ev.cpu;
            key_iface[slot] = ev.iface;
            key_start[slot] = ev.time_ns;
            key_count[slot] = 32'd1;
         end else if (ev.time_ns < key_start[slot] ||
                      ev.time_ns - key_start[slot] >= sh_window) begin
            key_start[slot] = ev.time_ns;
            key_count[slot] = 32'd1;
         end else begin
            r.elapsed = ev.time_ns - key_start[slot];
            if (key_count[slot] != wdrd_pkg::COUNT_MAX) key_count[slot]++;
            r.count = key_count[slot];
         end
         // promote the hit or replaced entry to most recent
         old = key_age[slot];
         for (int i = 0; i < NKEYS; i++)
            if (key_age[i] < old) key_age[i]++;
         key_age[slot] = '0;
         r.detail = (rsn > 32'(wdrd_pkg::DETAIL_MAX)) ? wdrd_pkg::DETAIL_MAX : rsn[7:0];
         r.status = wdrd_pkg::ST_COUNTED;
         if (r.count == sh_thresh) begin
            tot_events++;
            r.status = wdrd_pkg::ST_THRESHOLD;
         end
      end
      r.drops = tot_drops; r.unattr = tot_unattr; r.events = tot_events;
      return r;
   endfunction

   task automatic idle_burst();
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_drop(drop_event_type ev);
      idle_burst();
      start <= 1'b1;
      req_time_ns <= ev.time_ns;
      req_cpu_id <= ev.cpu;
      req_iface_id <= ev.iface;
      req_drop_protocol <= ev.proto;
      req_drop_reason <= ev.reason;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_reports.push_back(classify_drop(ev));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         wdrd_pkg::CSR_MATCH_PROTOCOL: sh_proto = val[15:0];
         wdrd_pkg::CSR_IFACE_FILTER:   sh_filter = val[31:0];
         wdrd_pkg::CSR_WINDOW_NS:      sh_window = val;
         wdrd_pkg::CSR_DROP_THRESHOLD: sh_thresh = val[31:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] p, logic [31:0] f, logic [63:0] w, logic [31:0] t);
      drain();
      write_csr(wdrd_pkg::CSR_MATCH_PROTOCOL, {48'd0, p});
      write_csr(wdrd_pkg::CSR_IFACE_FILTER, {32'd0, f});
      write_csr(wdrd_pkg::CSR_WINDOW_NS, w);
      write_csr(wdrd_pkg::CSR_DROP_THRESHOLD, {32'd0, t});
      csr_write <= 1'b0;
   endtask

   function automatic drop_event_type mk(logic [63:0] t, logic [2:0] c, logic [31:0] i,
                                         logic [15:0] p, logic [31:0] r);
      drop_event_type ev;
      ev.time_ns = t; ev.cpu = c; ev.iface = i; ev.proto = p; ev.reason = r;
      return ev;
   endfunction

   // Check each result against the oldest prediction
   always @(posedge clock) begin
      drop_report_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            e = pending_reports.pop_front();
            if (rsp_status !== e.status || rsp_window_count !== e.count ||
                rsp_elapsed_ns !== e.elapsed || rsp_reason_detail !== e.detail ||
                rsp_event_iface !== e.iface || rsp_event_cpu !== e.cpu ||
                rsp_event_time !== e.time_ns || rsp_drops_total !== e.drops ||
                rsp_unattributed_total !== e.unattr || rsp_events_total !== e.events) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st=%0d cnt=%0d el=%0d det=%0d if=%0h cpu=%0d",
                           e.status, e.count, e.elapsed, e.detail, e.iface, e.cpu);
                  $display("          exp t=%0h tot=%0d/%0d/%0d",
                           e.time_ns, e.drops, e.unattr, e.events);
                  $display("          got st=%0d cnt=%0d el=%0d det=%0d if=%0h cpu=%0d",
                           rsp_status, rsp_window_count, rsp_elapsed_ns,
                           rsp_reason_detail, rsp_event_iface, rsp_event_cpu);
                  $display("          got t=%0h tot=%0d/%0d/%0d", rsp_event_time,
                           rsp_drops_total, rsp_unattributed_total, rsp_events_total);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_classification();
      configure(16'h0800, 32'd0, 64'd100, 32'd3);
      send_drop(mk(64'd10, 3'd0, 32'd5, 16'h0801, 32'd1));        // wrong protocol
      send_drop(mk(64'd11, 3'd1, 32'd0, 16'h0800, 32'd1));        // unattributed
      send_drop(mk(64'd12, 3'd2, 32'hffffffff, 16'h0800, 32'h80000000)); // negative reason
      send_drop(mk(64'd13, 3'd2, 32'hffffffff, 16'h0800, 32'h7fffffff)); // saturated reason
      send_drop(mk(64'd14, 3'd2, 32'hffffffff, 16'h0800, 32'd255)); // threshold hit
      send_drop(mk(64'd5, 3'd2, 32'hffffffff, 16'h0800, 32'd7));    // time went backwards
      send_drop(mk(64'd200, 3'd2, 32'hffffffff, 16'h0800, 32'd7));  // window expired
      send_drop(mk(64'd201, 3'd7, 32'd9, 16'h0800, 32'd0));
      configure(16'hffff, 32'd9, 64'd0, 32'd0);
      send_drop(mk(64'd300, 3'd7, 32'd9, 16'hffff, 32'd1));     // window zero restarts
      send_drop(mk(64'd301, 3'd7, 32'd8, 16'hffff, 32'd1));     // filtered
      send_drop(mk(64'hffffffffffffffff, 3'd7, 32'd9, 16'hffff, 32'd1));
      // fill beyond the table to force replacement
      configure(16'd0, 32'd0, 64'hffffffffffffffff, 32'd1);
      for (int i = 1; i <= 18; i++)
         send_drop(mk(64'(i), 3'(i), 32'(i), 16'd0, 32'(i)));
   endtask

   task automatic test_random(int n);
      drop_event_type ev;
      logic [63:0] tnow;
      tnow = 64'd0;
      for (int k = 0; k < n; k++) begin
         if (k % 150 == 0 && k < n - 150) begin
            case ($urandom_range(0, 3))
               0: configure(16'($urandom), 32'd0, {$urandom, $urandom}, $urandom);
               1: configure(16'd6, 32'd0, 64'($urandom_range(0, 60)), $urandom_range(0, 6));
               2: configure(16'd6, 32'($urandom_range(1, 3)), 64'd40, $urandom_range(1, 4));
               default: configure(16'd6, 32'd0, 64'hffffffffffffffff, 32'hffffffff);
            endcase
         end
         if (k == n - 150) idle_gaps = 1'b0;
         tnow += $urandom_range(0, 12);
         ev.time_ns = ($urandom_range(0, 29) == 0) ? {$urandom, $urandom} : tnow;
         ev.cpu = 3'($urandom_range(0, 7));
         ev.iface = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3));
         ev.proto = ($urandom_range(0, 7) == 0) ? 16'($urandom) : sh_proto;
         ev.reason = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 300));
         send_drop(ev);
      end
   endtask

   initial begin
      shadow_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_classification();
      test_random(930);
      drain();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
